// File: sv/qclt_pkg.sv
// Shared types and constants for the quoted command-line tokenizer.
// No dependencies; imported by qclt_core and quoted_command_line_tokenizer.
package qclt_pkg;

    localparam int QDEPTH  = 8;
    localparam int MAX_RES = 3;

    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;

    typedef enum logic [2:0] {
        RK_BYTE         = 3'd0,
        RK_END_ARG      = 3'd1,
        RK_END_LIST     = 3'd2,
        RK_MISPLACED    = 3'd3,
        RK_UNTERMINATED = 3'd4
    } t_rkind;

    typedef enum logic [2:0] {
        QM_NONE   = 3'b001,
        QM_SINGLE = 3'b010,
        QM_DOUBLE = 3'b100
    } t_qmode;

    typedef struct packed {
        t_qmode qm;
        logic   bs_pend;
        logic   has_content;
        logic   dropping;
        logic   failed;
    } t_tok_state;

    localparam t_tok_state ST_RESET = '{qm: QM_NONE, bs_pend: 1'b0, has_content: 1'b0,
                                        dropping: 1'b0, failed: 1'b0};

    typedef struct packed {
        t_rkind     kind;
        logic [7:0] data;
    } t_res;

    typedef struct packed {
        logic [1:0]         cnt;
        t_res [MAX_RES-1:0] r;
    } t_res_set;

    typedef struct packed {
        t_rkind     kind;
        logic [7:0] data;
        logic       last;
    } t_qent;

endpackage

// File: sv/qclt_core.sv
// Tokenizer step: next state and up to three results for one request.
// Depends on qclt_pkg.
module qclt_core
    import qclt_pkg::*;
(
    input  logic       i_kind,
    input  logic [7:0] i_byte_req,
    input  t_tok_state i_state,
    output t_tok_state o_state,
    output t_res_set   o_res
);

    typedef struct packed {
        t_tok_state st;
        t_res_set   rs;
    } t_work;

    function automatic t_work f_put(t_work w, t_rkind k, logic [7:0] d);
        t_work v;
        v = w;
        if (v.rs.cnt < 2'(MAX_RES)) begin
            v.rs.r[v.rs.cnt] = '{kind: k, data: d};
            v.rs.cnt         = v.rs.cnt + 2'd1;
        end
        return v;
    endfunction

    function automatic t_work f_end_arg(t_work w);
        t_work v;
        v = w;
        if (v.st.has_content && !v.st.dropping) begin
            v = f_put(v, RK_END_ARG, 8'h00);
        end
        v.st.has_content = 1'b0;
        v.st.dropping    = 1'b0;
        return v;
    endfunction

    function automatic t_work f_emit(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        if (!v.st.has_content) begin
            v.st.has_content = 1'b1;
            if (c == CH_PERCENT) begin
                v.st.dropping = 1'b1;
            end
        end
        if (!v.st.dropping) begin
            v = f_put(v, RK_BYTE, c);
        end
        return v;
    endfunction

    function automatic t_work f_plain(t_work w, logic [7:0] c);
        t_work v;
        v = w;
        priority if (c == CH_BSLASH && v.st.qm != QM_SINGLE) begin
            v.st.bs_pend = 1'b1;
        end else if (v.st.qm == QM_NONE && (c == CH_SQUOTE || c == CH_DQUOTE)) begin
            if (v.st.has_content) begin
                v = f_put(v, RK_MISPLACED, 8'h00);
                v.st.failed = 1'b1;
            end else begin
                v.st.qm       = (c == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
                v.st.dropping = 1'b0;
            end
        end else if ((v.st.qm == QM_SINGLE && c == CH_SQUOTE) ||
                     (v.st.qm == QM_DOUBLE && c == CH_DQUOTE)) begin
            if (!v.st.dropping) begin
                v = f_put(v, RK_END_ARG, 8'h00);
            end
            v.st.qm          = QM_NONE;
            v.st.has_content = 1'b0;
            v.st.dropping    = 1'b0;
        end else if (c == CH_SPACE && v.st.qm == QM_NONE) begin
            v = f_end_arg(v);
        end else begin
            v = f_emit(v, c);
        end
        return v;
    endfunction

    t_work w;
    logic  esc_deleted;

    always_comb begin
        w.st        = i_state;
        w.rs        = '0;
        esc_deleted = (i_byte_req == CH_DOLLAR) || (i_byte_req == CH_DQUOTE) ||
                      (i_byte_req == CH_BACKTICK) || (i_byte_req == CH_BSLASH) ||
                      (i_state.qm == QM_NONE &&
                       (i_byte_req == CH_SQUOTE || i_byte_req == CH_SPACE));
        if (i_kind) begin
            if (!i_state.failed) begin
                if (i_state.qm != QM_NONE) begin
                    w = f_put(w, RK_UNTERMINATED, 8'h00);
                end else begin
                    if (i_state.bs_pend) begin
                        w = f_emit(w, CH_BSLASH);
                    end
                    w = f_end_arg(w);
                    w = f_put(w, RK_END_LIST, 8'h00);
                end
            end
            w.st = ST_RESET;
        end else if (!i_state.failed) begin
            if (i_state.bs_pend) begin
                w.st.bs_pend = 1'b0;
                if (esc_deleted) begin
                    w = f_emit(w, i_byte_req);
                end else begin
                    w = f_emit(w, CH_BSLASH);
                    w = f_plain(w, i_byte_req);
                end
            end else begin
                w = f_plain(w, i_byte_req);
            end
        end
    end

    assign o_state = w.st;
    assign o_res   = w.rs;

endmodule

// File: sv/quoted_command_line_tokenizer.sv
// Quoted command-line tokenizer top level: tokenizer state and result queue.
// Depends on qclt_pkg and qclt_core.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one request per cycle while o_ready is
//   high: a command-line byte (i_kind = 0) or an end-of-string mark (i_kind = 1).
//   Output channel (o_valid/i_ready) gives results one per cycle while i_ready
//   is high: argument bytes, end of argument, end of list or a quote error; o_last
//   marks the final result of each request. A request may give no result.
//   A request's results are written into the queue when it is accepted and
//   are presented from it in order. Throughput: one request per cycle while each
//   gives at most one result; a request giving several results occupies the
//   output until each of its results is taken.
//   Results go into a P_QDEPTH-entry queue; o_ready is high while the queue
//   has room for the three results a request can give, so input keeps flowing
//   while earlier results wait.
//   When the receiver stalls the queue fills and o_ready drops; nothing is lost.
//   Reset (synchronous, active low) clears the tokenizer state and empties
//   the queue.
module quoted_command_line_tokenizer
    import qclt_pkg::*;
#(
    parameter int P_QDEPTH = QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_byte_req,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_result_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    localparam int PW = $clog2(P_QDEPTH);
    localparam int CW = $clog2(P_QDEPTH + 1);

    t_tok_state r_state, n_state;
    t_res_set   res;
    t_qent      r_q [P_QDEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic acc_in, acc_out;

    qclt_core u_core (
        .i_kind    (i_kind),
        .i_byte_req(i_byte_req),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_res     (res)
    );

    assign o_ready = (r_count <= CW'(P_QDEPTH - MAX_RES));
    assign o_valid = (r_count != '0);
    assign acc_in  = i_valid && o_ready;
    assign acc_out = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RESET;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (acc_in) begin
                r_state  <= n_state;
                r_wr_ptr <= r_wr_ptr + PW'(res.cnt);
            end
            if (acc_out) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + (acc_in ? CW'(res.cnt) : CW'(0)) - CW'(acc_out);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RES; j++) begin
            if (acc_in && (2'(j) < res.cnt)) begin
                r_q[r_wr_ptr + PW'(j)] <= '{kind: res.r[j].kind, data: res.r[j].data,
                                            last: (2'(j) == res.cnt - 2'd1)};
            end
        end
    end

    assign o_result_kind = r_q[r_rd_ptr].kind;
    assign o_out_byte    = r_q[r_rd_ptr].data;
    assign o_last        = r_q[r_rd_ptr].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_QDEPTH))
        else $error("result queue overflow");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_kind) |=> (r_state == ST_RESET))
        else $error("state not cleared after end of string");

    a_qm_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.qm))
        else $error("quote mode not one-hot");

    a_failed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && r_state.failed) |-> (res.cnt == 2'd0))
        else $error("result produced after error");

endmodule
